>>> rtl/coverage_change_point_collapse_macros.svh
// ----------------------------------------------------------------------------
// Coverage change-point collapse: assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef COVERAGE_CHANGE_POINT_COLLAPSE_MACROS_SVH
`define COVERAGE_CHANGE_POINT_COLLAPSE_MACROS_SVH

// Same-cycle implication
`define CCPC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ccpc assertion failed");

// Next-cycle implication
`define CCPC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ccpc assertion failed");

`endif

>>> rtl/ccpc_pkg.sv
// ----------------------------------------------------------------------------
// ccpc_pkg
// Types and constants shared by the change-point collapse modules.
// ----------------------------------------------------------------------------
package ccpc_pkg;

	localparam int POS_W   = 32;
	localparam int DEPTH_W = 32;
	// Up to three points per event: a change point, the flushed run, the tail run
	localparam int NPTS    = 3;
	localparam int QDEPTH  = 4;
	localparam int QAW     = $clog2(QDEPTH);
	localparam int QCW     = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [POS_W-1:0]          pos;
		logic signed [DEPTH_W-1:0] depth;
		logic                      last;
	} point_t;

	// Points caused by one event; mask bit i marks pts[i] as present
	typedef struct packed {
		logic [NPTS-1:0]     mask;
		point_t [NPTS-1:0]   pts;
	} bundle_t;

	typedef struct packed {
		logic            full;
		logic            empty;
		logic [QCW-1:0]  count;
	} qstat_t;

endpackage

>>> rtl/ccpc_front.sv
// ----------------------------------------------------------------------------
// ccpc_front
// Accepts events, updates running depth and pending run, and builds the
// bundle of change points each event causes.
// ----------------------------------------------------------------------------
module ccpc_front import ccpc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      q_full,
	input  logic [POS_W-1:0]          event_position,
	input  logic signed [DEPTH_W-1:0] event_delta,
	input  logic                      final_event,
	output logic                      in_ready,
	output logic                      push,
	output bundle_t                   bundle
);

	logic [POS_W-1:0]          cursor_q;
	logic signed [DEPTH_W-1:0] run_q;
	logic [POS_W-1:0]          pend_start_q;
	logic signed [DEPTH_W-1:0] pend_depth_q;

	logic                      accept;
	logic                      emit_chg;
	logic [POS_W-1:0]          pstart_n;
	logic signed [DEPTH_W-1:0] pdepth_n;
	logic signed [DEPTH_W-1:0] run_n;
	logic                      differ;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Classify the event and compute next state
	always_comb begin
		emit_chg = (event_position != cursor_q) && (run_q != pend_depth_q);
		pdepth_n = emit_chg ? run_q : pend_depth_q;
		pstart_n = emit_chg ? cursor_q : pend_start_q;
		run_n    = run_q + event_delta;
		if (event_position == '0) begin
			pdepth_n = run_n;
		end
		differ = (run_n != pdepth_n);

		bundle.pts[0].pos   = pend_start_q;
		bundle.pts[0].depth = pend_depth_q;
		bundle.pts[0].last  = 1'b0;
		bundle.pts[1].pos   = pstart_n;
		bundle.pts[1].depth = pdepth_n;
		bundle.pts[1].last  = !differ;
		bundle.pts[2].pos   = event_position;
		bundle.pts[2].depth = run_n;
		bundle.pts[2].last  = 1'b1;
		bundle.mask = {final_event && differ, final_event, emit_chg};
	end

	assign push = accept && (bundle.mask != '0);

	// Running state; a final event returns it to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q     <= '0;
			run_q        <= '0;
			pend_start_q <= '0;
			pend_depth_q <= '0;
		end else if (accept) begin
			if (final_event) begin
				cursor_q     <= '0;
				run_q        <= '0;
				pend_start_q <= '0;
				pend_depth_q <= '0;
			end else begin
				cursor_q     <= event_position;
				run_q        <= run_n;
				pend_start_q <= pstart_n;
				pend_depth_q <= pdepth_n;
			end
		end
	end

endmodule

>>> rtl/ccpc_queue.sv
// ----------------------------------------------------------------------------
// ccpc_queue
// Short FIFO of point bundles between the front and back parts.
// ----------------------------------------------------------------------------
module ccpc_queue import ccpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	input  logic    pop,
	output bundle_t head,
	output qstat_t  stat
);

	bundle_t         entries_q [QDEPTH];
	logic [QAW-1:0]  wr_ptr_q;
	logic [QAW-1:0]  rd_ptr_q;
	logic [QCW-1:0]  count_q;
	logic            do_push;
	logic            do_pop;

	assign stat.count = count_q;
	assign stat.full  = (count_q == QCW'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = entries_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/ccpc_back.sv
// ----------------------------------------------------------------------------
// ccpc_back
// Takes the head bundle apart one point per cycle, unless stalled, into out_point.
// ----------------------------------------------------------------------------
module ccpc_back import ccpc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  bundle_t             head,
	input  logic                q_empty,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output point_t              out_point
);

	logic [NPTS-1:0] done_q;
	logic [NPTS-1:0] remain;
	logic [NPTS-1:0] pick;
	logic            load;
	logic            advance;
	logic            out_valid_q;
	point_t          out_point_q;
	point_t          sel;

	assign out_valid = out_valid_q;
	assign out_point = out_point_q;
	assign load      = !out_valid_q || out_ready;
	assign advance   = load && !q_empty;

	// Lowest point of the head bundle not yet sent
	always_comb begin
		remain = head.mask & ~done_q;
		pick   = remain & (~remain + 1'b1);
		sel    = head.pts[0];
		for (int i = 0; i < NPTS; i++) begin
			if (pick[i]) begin
				sel = head.pts[i];
			end
		end
		pop = advance && ((remain & ~pick) == '0);
	end

	// Sent-point mask for the head bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (advance) begin
			done_q <= pop ? '0 : (done_q | pick);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_point_q <= sel;
		end
	end

endmodule

>>> rtl/coverage_change_point_collapse.sv
// ----------------------------------------------------------------------------
// coverage_change_point_collapse
// Collapses a sorted stream of coverage events into constant-depth runs.
// ----------------------------------------------------------------------------
// Input channel s_*: one event per item: position, signed depth change, and
// tlast on the final event of a sequence. Output channel m_*: one change
// point per item: run start, depth, and tlast on the sequence's last point.
// An event yields zero to three points. It is accepted whenever the four-entry
// bundle queue has room, so events enter at one per cycle. An event's bundle is
// written into the queue and then loaded into the output register, where
// m_tvalid rises for its point. The output side sends one point per cycle
// while m_tready is high, so sustained rate is set by the output port, and an
// event that flushes a sequence puts up to three points through it.
// When the receiver stalls, the output register holds its point and the
// queue absorbs up to four more point-producing events before s_tready drops;
// events that produce no point never take a queue entry.
// Reset clears running depth, pending run, queue and output valid flag; the
// block is ready for an event as soon as reset is released.
// ----------------------------------------------------------------------------
module coverage_change_point_collapse import ccpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] event_position, [63:32] event_delta
	input  logic        s_tlast,   // final_event
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] run_position, [63:32] run_depth
	output logic        m_tlast    // run_last
);

	logic    push;
	logic    pop;
	bundle_t bundle;
	bundle_t head;
	qstat_t  qstat;
	point_t  out_point;

	ccpc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.q_full         (qstat.full),
		.event_position (s_tdata[31:0]),
		.event_delta    (s_tdata[63:32]),
		.final_event    (s_tlast),
		.in_ready       (s_tready),
		.push           (push),
		.bundle         (bundle)
	);

	ccpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (bundle),
		.pop       (pop),
		.head      (head),
		.stat      (qstat)
	);

	ccpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (qstat.empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_point (out_point)
	);

	assign m_tdata = {out_point.depth, out_point.pos};
	assign m_tlast = out_point.last;

	// Checks
	`include "coverage_change_point_collapse_macros.svh"

	`CCPC_ASSERT_IMP(a_ready_full, !s_tready, qstat.count == QCW'(QDEPTH))
	`CCPC_ASSERT_IMP(a_push_nonempty, push, bundle.mask != '0)
	`CCPC_ASSERT_IMP(a_pop_has_data, pop, !qstat.empty)
	`CCPC_ASSERT_NXT(a_pop_loads, pop, m_tvalid)

endmodule
